FILE: hw/rtl/tcx_pkg.sv
`default_nettype none
package tcx_pkg;

   localparam int MAX_SAMPLES_DEF = 256;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic ST_VALID      = 1'b0;
   localparam logic ST_DEGENERATE = 1'b1;

   localparam logic [63:0] PS_BIG    = 64'd65536000000000;
   localparam logic [63:0] RATE_CAP  = 64'h4000_0000_0000_0000;
   localparam logic [63:0] LN2_Q32   = 64'd2977044472;
   localparam logic [63:0] LN2_RECIP = 64'hFFFF_FFFF_FFFF_FFFF / LN2_Q32;
   localparam logic [63:0] EXP_LIMIT = 64'h0000_0020_0000_0000;
   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [3:0]  SERIES_TERMS = 4'd13;

   localparam logic [6:0] STEPS_PS   = 7'd64;
   localparam logic [6:0] STEPS_RATE = 7'd94;
   localparam logic [6:0] STEPS_FRAC = 7'd30;
   localparam logic [6:0] STEPS_TERM = 7'd32;
   localparam logic [6:0] STEPS_SQRT = 7'd64;

endpackage
`default_nettype wire

FILE: hw/rtl/two_compartment_exchange_curve_core.sv
`default_nettype none
// Two-compartment exchange tissue curve. A load beat (operation 0) writes one sample time and
// arterial input value and gives no result; busy stays low. An evaluate beat (operation 1)
// keeps busy high through setup (PS, rates, square root, Eneg), then through every stored
// sample from 0 up to the point, where the bit-serial divider works the 13-term exponential
// series twice per sample, and then through the final scaling. An evaluate with a zero vp, ve,
// Ktrans or Fp answers in the next cycle with status set. Each result sits on the rsp_ ports
// for one cycle under rsp_valid; the receiver cannot stall, so take it when it appears.
module two_compartment_exchange_curve_core #(
   parameter int MAX_SAMPLES = tcx_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_operation,
   input  wire logic [7:0]         req_sample_index,
   input  wire logic [31:0]        req_sample_time,
   input  wire logic signed [31:0] req_input_value,
   input  wire logic [30:0]        req_plasma_volume,
   input  wire logic [30:0]        req_extravascular_volume,
   input  wire logic [31:0]        req_transfer_constant,
   input  wire logic [31:0]        req_plasma_flow,
   input  wire logic [7:0]         req_point_index,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_concentration,
   output logic                    rsp_status
);
   import tcx_pkg::*;

   localparam int AW = $clog2(MAX_SAMPLES);

   typedef enum logic [5:0] {
      S_IDLE, S_PS0, S_PS1, S_PS2, S_R0, S_R1, S_R2, S_R3, S_R4, S_Q0, S_Q1, S_Q2,
      S_E0, S_E1, S_T0, S_T1, S_L0, S_L1, S_X0, S_X1, S_X2, S_XR, S_X3, S_X4, S_X5, S_X6,
      S_XF, S_C0, S_C1, S_C2, S_C3, S_C4, S_F0, S_F1, S_MUL, S_DIV, S_SQRT
   } state_type;

   state_type state_ff, ret_ff;

   logic [31:0] time_mem [MAX_SAMPLES];
   logic [31:0] input_mem [MAX_SAMPLES];
   logic [31:0] mem_time_q_ff, mem_in_q_ff;
   logic [AW-1:0] rd_addr;

   logic [30:0] vp_ff, ve_ff;
   logic [31:0] kt_ff, fp_ff;
   logic [AW-1:0] p_ff, i_ff;
   logic [63:0] ps_ff, a_ff, kpos_ff, kneg_ff;
   logic [62:0] rp_ff, re_ff, rb_ff;
   logic [127:0] sq_ff;
   logic [30:0] e_ff;

   logic [63:0] wm_x_ff, wm_y_ff, prod_ff;
   logic [2:0]  wm_cnt_ff;
   logic [127:0] acc_ff;
   logic [31:0] mul_a, mul_b;

   logic [63:0] dv_rem_ff, dv_num_ff, dv_den_ff, dv_quo_ff;
   logic        dv_ovf_ff;
   logic [6:0]  dv_cnt_ff;
   logic [64:0] dv_rt, dv_diff;
   logic        dv_ge;

   logic [127:0] sr_src_ff;
   logic [65:0]  sr_rem_ff;
   logic [63:0]  sr_root_ff;
   logic [6:0]   sr_cnt_ff;
   logic [67:0]  sr_rt, sr_trial, sr_diff;
   logic         sr_ge;

   logic [31:0] tp_ff, tj_ff, tprev_ff, d_ff, r_ff;
   logic signed [31:0] cp_ff;
   logic        sel_ff, sneg_ff, cneg_ff;
   logic [5:0]  n_ff;
   logic [32:0] t_ff;
   logic [63:0] pos_ff, neg_ff, tmp_ff, y_ff;
   logic [3:0]  j_ff;
   logic [30:0] ep_ff, en_ff, x_res_ff;
   logic signed [32:0] prev_ff;
   logic signed [63:0] conv_ff;

   logic        rsp_valid_ff, rsp_status_ff;
   logic [31:0] rsp_conc_ff;

   logic        mc_go, dc_go;
   logic [63:0] mc_x, mc_y, dc_rem, dc_num, dc_den;
   logic [6:0]  dc_steps;
   state_type   call_ret;

   logic        idx_ok, pt_ok, any_zero;
   logic [63:0] exp_k, e_num, e_den, mag;
   logic [127:0] four_b, disc;
   logic [63:0] s_cap;
   logic [64:0] a_plus, a_minus;
   logic [63:0] x_s, x_rnd, x_val, x_r0;
   logic [6:0]  x_sh1, x_sh2;
   logic [63:0] resp_sum;
   logic [30:0] resp_new;
   logic signed [32:0] cp_ext;
   logic [32:0] cp_abs;
   logic signed [63:0] term_v, term_r;
   logic signed [32:0] cur;
   logic signed [33:0] tsum;
   logic signed [32:0] tsp;
   logic [32:0] ms;
   logic [31:0] mw;
   logic [63:0] slice_rnd;
   logic [46:0] slice;
   logic [48:0] fin_res, fin_sat;

   function automatic logic [62:0] rate_cap(input logic [63:0] q, input logic ovf);
      return (ovf || q > RATE_CAP) ? RATE_CAP[62:0] : q[62:0];
   endfunction

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_concentration = rsp_conc_ff;
   assign rsp_status = rsp_status_ff;

   assign idx_ok = int'(req_sample_index) < MAX_SAMPLES;
   assign pt_ok = int'(req_point_index) < MAX_SAMPLES;
   assign any_zero = (req_plasma_volume == '0) || (req_extravascular_volume == '0) ||
                     (req_transfer_constant == '0) || (req_plasma_flow == '0);

   assign rd_addr = (state_ff == S_T0) ? p_ff : i_ff;

   always_ff @(posedge clock) begin
      if (start && !busy && req_operation == OP_LOAD && idx_ok) begin
         time_mem[AW'(req_sample_index)] <= req_sample_time;
         input_mem[AW'(req_sample_index)] <= req_input_value;
      end
      mem_time_q_ff <= time_mem[rd_addr];
      mem_in_q_ff <= input_mem[rd_addr];
   end

   assign mul_a = wm_cnt_ff[1] ? wm_x_ff[63:32] : wm_x_ff[31:0];
   assign mul_b = wm_cnt_ff[0] ? wm_y_ff[63:32] : wm_y_ff[31:0];

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      dv_rt = {dv_rem_ff, dv_num_ff[63]};
      dv_ge = dv_rt >= {1'b0, dv_den_ff};
      dv_diff = dv_rt - {1'b0, dv_den_ff};
      sr_rt = {sr_rem_ff, sr_src_ff[127:126]};
      sr_trial = {2'b00, sr_root_ff, 2'b01};
      sr_ge = sr_rt >= sr_trial;
      sr_diff = sr_rt - sr_trial;

      four_b = acc_ff << 2;
      disc = (sq_ff > four_b) ? sq_ff - four_b : '0;
      s_cap = (sr_root_ff > a_ff) ? a_ff : sr_root_ff;
      a_plus = {1'b0, a_ff} + {1'b0, s_cap};
      a_minus = {1'b0, a_ff} - {1'b0, s_cap};

      e_num = (kpos_ff > 64'(rb_ff)) ? kpos_ff - 64'(rb_ff) : '0;
      e_den = kpos_ff - kneg_ff;
      exp_k = sel_ff ? kneg_ff : kpos_ff;

      x_r0 = y_ff - acc_ff[63:0];
      x_s = pos_ff - neg_ff;
      x_sh1 = 7'(n_ff) + 7'd1;
      x_sh2 = 7'(n_ff) + 7'd2;
      x_rnd = x_s + (64'd1 << x_sh1);
      x_val = x_rnd >> x_sh2;

      resp_sum = tmp_ff + acc_ff[63:0] + 64'd536870912;
      resp_new = resp_sum[60:30];
      cp_ext = {cp_ff[31], cp_ff};
      cp_abs = cp_ff[31] ? 33'(-cp_ext) : 33'(cp_ext);

      term_v = cp_ff[31] ? -$signed(acc_ff[63:0]) : $signed(acc_ff[63:0]);
      term_r = term_v + 64'sd536870912;
      cur = 33'(term_r >>> 30);
      tsum = {cur[32], cur} + {prev_ff[32], prev_ff};
      tsp = $signed({1'b0, tj_ff}) - $signed({1'b0, tprev_ff});
      ms = tsum[33] ? 33'(-tsum) : 33'(tsum);
      mw = tsp[32] ? 32'(-tsp) : 32'(tsp);

      slice_rnd = acc_ff[63:0] + 64'd65536;
      slice = slice_rnd[63:17];

      mag = conv_ff[63] ? 64'(-conv_ff) : 64'(conv_ff);
      fin_res = (acc_ff[127:64] != '0) ? 49'h1_0000_0000
                                       : 49'(acc_ff[63:16]) + 49'(acc_ff[15]);
      fin_sat = fin_res;
      if (!cneg_ff && fin_res > 49'h0_7FFF_FFFF) fin_sat = 49'h0_7FFF_FFFF;
      if (cneg_ff && fin_res > 49'h0_8000_0000) fin_sat = 49'h0_8000_0000;
   end

   always_comb begin
      mc_go = 1'b0;
      mc_x = '0;
      mc_y = '0;
      dc_go = 1'b0;
      dc_rem = '0;
      dc_num = '0;
      dc_den = '0;
      dc_steps = '0;
      call_ret = S_IDLE;
      unique case (state_ff)
         S_PS0: if (kt_ff < fp_ff) begin
            mc_go = 1'b1; mc_x = 64'(fp_ff); mc_y = 64'(kt_ff); call_ret = S_PS1;
         end
         S_PS1: begin
            dc_go = 1'b1; dc_num = acc_ff[63:0]; dc_den = 64'(fp_ff - kt_ff);
            dc_steps = STEPS_PS; call_ret = S_PS2;
         end
         S_R0: begin
            dc_go = 1'b1; dc_num = ps_ff + 64'(fp_ff); dc_den = 64'(vp_ff);
            dc_steps = STEPS_RATE; call_ret = S_R1;
         end
         S_R1: begin
            dc_go = 1'b1; dc_num = ps_ff; dc_den = 64'(ve_ff);
            dc_steps = STEPS_RATE; call_ret = S_R2;
         end
         S_R2: begin
            dc_go = 1'b1; dc_num = 64'(fp_ff); dc_den = 64'(vp_ff);
            dc_steps = STEPS_RATE; call_ret = S_R3;
         end
         S_R4: begin
            mc_go = 1'b1; mc_x = a_ff; mc_y = a_ff; call_ret = S_Q0;
         end
         S_Q0: begin
            mc_go = 1'b1; mc_x = 64'(re_ff); mc_y = 64'(rb_ff); call_ret = S_Q1;
         end
         S_E0: if (e_den != '0 && e_num < e_den) begin
            dc_go = 1'b1; dc_rem = e_num; dc_den = e_den;
            dc_steps = STEPS_FRAC; call_ret = S_E1;
         end
         S_X0: if (d_ff != '0 && exp_k != '0) begin
            mc_go = 1'b1; mc_x = 64'(d_ff); mc_y = exp_k; call_ret = S_X1;
         end
         S_X1: if (acc_ff <= 128'(EXP_LIMIT)) begin
            mc_go = 1'b1; mc_x = acc_ff[63:0]; mc_y = LN2_RECIP; call_ret = S_X2;
         end
         S_X2: begin
            mc_go = 1'b1; mc_x = 64'(acc_ff[69:64]); mc_y = LN2_Q32; call_ret = S_XR;
         end
         S_X3: begin
            mc_go = 1'b1; mc_x = 64'(t_ff); mc_y = 64'(r_ff); call_ret = S_X4;
         end
         S_X4: begin
            dc_go = 1'b1; dc_num = {acc_ff[63:32], 32'b0}; dc_den = 64'(j_ff);
            dc_steps = STEPS_TERM; call_ret = S_X5;
         end
         S_C0: begin
            mc_go = 1'b1; mc_x = 64'(ONE_Q30 - e_ff); mc_y = 64'(ep_ff); call_ret = S_C1;
         end
         S_C1: begin
            mc_go = 1'b1; mc_x = 64'(e_ff); mc_y = 64'(en_ff); call_ret = S_C2;
         end
         S_C2: begin
            mc_go = 1'b1; mc_x = 64'(cp_abs); mc_y = 64'(resp_new); call_ret = S_C3;
         end
         S_C3: if (i_ff != '0) begin
            mc_go = 1'b1; mc_x = 64'(ms); mc_y = 64'(mw); call_ret = S_C4;
         end
         S_F0: begin
            mc_go = 1'b1; mc_x = mag; mc_y = 64'(fp_ff); call_ret = S_F1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start && req_operation == OP_EVAL) begin
               vp_ff <= req_plasma_volume;
               ve_ff <= req_extravascular_volume;
               kt_ff <= req_transfer_constant;
               fp_ff <= req_plasma_flow;
               p_ff <= pt_ok ? AW'(req_point_index) : AW'(MAX_SAMPLES - 1);
               if (any_zero) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_conc_ff <= '0;
                  rsp_status_ff <= ST_DEGENERATE;
               end else begin
                  state_ff <= S_PS0;
               end
            end
            S_PS0: if (kt_ff >= fp_ff) begin
               ps_ff <= PS_BIG;
               state_ff <= S_R0;
            end
            S_PS2: begin
               ps_ff <= (dv_quo_ff > PS_BIG) ? PS_BIG : dv_quo_ff;
               state_ff <= S_R0;
            end
            S_R1: rp_ff <= rate_cap(dv_quo_ff, dv_ovf_ff);
            S_R2: re_ff <= rate_cap(dv_quo_ff, dv_ovf_ff);
            S_R3: begin
               rb_ff <= rate_cap(dv_quo_ff, dv_ovf_ff);
               a_ff <= 64'(rp_ff) + 64'(re_ff);
               state_ff <= S_R4;
            end
            S_Q0: sq_ff <= acc_ff;
            S_Q1: begin
               sr_src_ff <= disc;
               sr_rem_ff <= '0;
               sr_root_ff <= '0;
               sr_cnt_ff <= STEPS_SQRT;
               state_ff <= S_SQRT;
            end
            S_Q2: begin
               kpos_ff <= a_plus[64:1];
               kneg_ff <= a_minus[64:1];
               state_ff <= S_E0;
            end
            S_E0: if (e_den == '0) begin
               e_ff <= '0;
               state_ff <= S_T0;
            end else if (e_num >= e_den) begin
               e_ff <= ONE_Q30;
               state_ff <= S_T0;
            end
            S_E1: begin
               e_ff <= dv_quo_ff[30:0];
               state_ff <= S_T0;
            end
            S_T0: state_ff <= S_T1;
            S_T1: begin
               tp_ff <= mem_time_q_ff;
               conv_ff <= '0;
               i_ff <= '0;
               state_ff <= S_L0;
            end
            S_L0: state_ff <= S_L1;
            S_L1: begin
               tj_ff <= mem_time_q_ff;
               cp_ff <= mem_in_q_ff;
               d_ff <= (tp_ff >= mem_time_q_ff) ? tp_ff - mem_time_q_ff : '0;
               sel_ff <= 1'b0;
               state_ff <= S_X0;
            end
            S_X0: if (d_ff == '0 || exp_k == '0) begin
               x_res_ff <= ONE_Q30;
               state_ff <= S_XF;
            end
            S_X1: begin
               y_ff <= acc_ff[63:0];
               if (acc_ff > 128'(EXP_LIMIT)) begin
                  x_res_ff <= '0;
                  state_ff <= S_XF;
               end
            end
            S_X2: n_ff <= acc_ff[69:64];
            S_XR: begin
               if (x_r0 >= LN2_Q32) begin
                  n_ff <= n_ff + 6'd1;
                  r_ff <= 32'(x_r0 - LN2_Q32);
               end else begin
                  r_ff <= x_r0[31:0];
               end
               t_ff <= 33'h1_0000_0000;
               pos_ff <= 64'h1_0000_0000;
               neg_ff <= '0;
               j_ff <= 4'd1;
               state_ff <= S_X3;
            end
            S_X5: begin
               t_ff <= {1'b0, dv_quo_ff[31:0]};
               if (j_ff[0]) neg_ff <= neg_ff + 64'(dv_quo_ff[31:0]);
               else         pos_ff <= pos_ff + 64'(dv_quo_ff[31:0]);
               if (j_ff == SERIES_TERMS) begin
                  state_ff <= S_X6;
               end else begin
                  j_ff <= j_ff + 4'd1;
                  state_ff <= S_X3;
               end
            end
            S_X6: begin
               x_res_ff <= x_val[30:0];
               state_ff <= S_XF;
            end
            S_XF: if (!sel_ff) begin
               ep_ff <= x_res_ff;
               sel_ff <= 1'b1;
               state_ff <= S_X0;
            end else begin
               en_ff <= x_res_ff;
               state_ff <= S_C0;
            end
            S_C1: tmp_ff <= acc_ff[63:0];
            S_C3: begin
               prev_ff <= cur;
               tprev_ff <= tj_ff;
               sneg_ff <= tsum[33] ^ tsp[32];
               if (i_ff == '0) begin
                  if (p_ff == '0) begin
                     state_ff <= S_F0;
                  end else begin
                     i_ff <= i_ff + AW'(1);
                     state_ff <= S_L0;
                  end
               end
            end
            S_C4: begin
               conv_ff <= sneg_ff ? conv_ff - $signed(64'(slice))
                                  : conv_ff + $signed(64'(slice));
               if (i_ff == p_ff) begin
                  state_ff <= S_F0;
               end else begin
                  i_ff <= i_ff + AW'(1);
                  state_ff <= S_L0;
               end
            end
            S_F0: cneg_ff <= conv_ff[63];
            S_F1: begin
               rsp_valid_ff <= 1'b1;
               rsp_conc_ff <= cneg_ff ? 32'(-fin_sat) : fin_sat[31:0];
               rsp_status_ff <= ST_VALID;
               state_ff <= S_IDLE;
            end
            S_MUL: begin
               unique case (wm_cnt_ff)
                  3'd0: ;
                  3'd1: acc_ff <= acc_ff + 128'(prod_ff);
                  3'd2, 3'd3: acc_ff <= acc_ff + (128'(prod_ff) << 32);
                  default: begin
                     acc_ff <= acc_ff + (128'(prod_ff) << 64);
                     state_ff <= ret_ff;
                  end
               endcase
               wm_cnt_ff <= wm_cnt_ff + 3'd1;
            end
            S_DIV: begin
               dv_rem_ff <= dv_ge ? dv_diff[63:0] : dv_rt[63:0];
               dv_quo_ff <= {dv_quo_ff[62:0], dv_ge};
               dv_ovf_ff <= dv_ovf_ff | dv_quo_ff[63];
               dv_num_ff <= dv_num_ff << 1;
               dv_cnt_ff <= dv_cnt_ff - 7'd1;
               if (dv_cnt_ff == 7'd1) state_ff <= ret_ff;
            end
            S_SQRT: begin
               sr_rem_ff <= sr_ge ? sr_diff[65:0] : sr_rt[65:0];
               sr_root_ff <= {sr_root_ff[62:0], sr_ge};
               sr_src_ff <= sr_src_ff << 2;
               sr_cnt_ff <= sr_cnt_ff - 7'd1;
               if (sr_cnt_ff == 7'd1) state_ff <= S_Q2;
            end
            default: ;
         endcase
         if (mc_go) begin
            wm_x_ff <= mc_x;
            wm_y_ff <= mc_y;
            wm_cnt_ff <= '0;
            acc_ff <= '0;
            ret_ff <= call_ret;
            state_ff <= S_MUL;
         end
         if (dc_go) begin
            dv_rem_ff <= dc_rem;
            dv_num_ff <= dc_num;
            dv_den_ff <= dc_den;
            dv_quo_ff <= '0;
            dv_ovf_ff <= 1'b0;
            dv_cnt_ff <= dc_steps;
            ret_ff <= call_ret;
            state_ff <= S_DIV;
         end
      end
   end

endmodule
`default_nettype wire
